[rtl/gpfe_pkg.sv]
package gpfe_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned MAX_SAMPLES_DEF = 4096;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	// Field and register widths
	localparam int unsigned THR_W      = 16;
	localparam int unsigned GS_W       = 12;
	localparam int unsigned GL_W       = 13;
	localparam int unsigned PER_W      = 16;
	localparam int unsigned SUM_W      = 44;
	localparam int unsigned PEAK_W     = 16;
	localparam int unsigned TOT_W      = 28;
	localparam int unsigned TOA_W      = 29;
	localparam int unsigned TOP_W      = 28;
	localparam int unsigned OFF_W      = 13;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Low part of the split integral multiply
	localparam int unsigned SUM_LO_W = 32;
	localparam int unsigned SUM_HI_W = SUM_W - SUM_LO_W;

	// Depth of the summary queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register reset values
	localparam logic signed [THR_W-1:0] THRESHOLD_RST     = '0;
	localparam logic [GS_W-1:0]         GATE_START_RST    = '0;
	localparam logic [GL_W-1:0]         GATE_LENGTH_RST   = GL_W'(4096);
	localparam logic [PER_W-1:0]        SAMPLE_PERIOD_RST = PER_W'(1000);

	// Arrival time reported when the result is suppressed (-1)
	localparam logic [TOA_W-1:0] ARRIVAL_NONE = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD     = 2'd0,
		REG_GATE_START    = 2'd1,
		REG_GATE_LENGTH   = 2'd2,
		REG_SAMPLE_PERIOD = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [THR_W-1:0] threshold;
		logic [GS_W-1:0]         gate_start;
		logic [GL_W-1:0]         gate_length;
		logic [PER_W-1:0]        sample_period;
	} cfg_t;

	// Per-waveform summary handed from front to back
	typedef struct packed {
		logic              hit;
		logic [SUM_W-1:0]  sum;
		logic [PEAK_W-1:0] peak;
		logic [OFF_W-1:0]  over_count;
		logic [OFF_W-1:0]  arrival_offset;
		logic [OFF_W-1:0]  peak_offset;
	} summary_t;

endpackage

[rtl/gpfe_sample_if.sv]
interface gpfe_sample_if #(
	parameter int unsigned SAMPLE_BITS = gpfe_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

[rtl/gpfe_result_if.sv]
interface gpfe_result_if ();
	import gpfe_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    above_threshold;
	logic signed [SUM_W-1:0] integral;
	logic signed [PEAK_W-1:0] peak_value;
	logic [TOT_W-1:0]        time_over_threshold;
	logic signed [TOA_W-1:0] time_of_arrival;
	logic [TOP_W-1:0]        time_of_peak;

	modport source (
		output valid, output above_threshold, output integral, output peak_value,
		output time_over_threshold, output time_of_arrival, output time_of_peak,
		input ready
	);
	modport sink (
		input valid, input above_threshold, input integral, input peak_value,
		input time_over_threshold, input time_of_arrival, input time_of_peak,
		output ready
	);
endinterface

[rtl/gated_pulse_feature_extractor.sv]
// Gated pulse feature extractor. Feed waveform samples on the samples channel,
// marking the final sample of each waveform with last_sample; one result
// transaction follows each waveform on the results channel. Samples whose index
// (counted from zero per waveform, saturating at MAX_SAMPLES) falls inside
// [gate_start, gate_start + gate_length) contribute the integral, the peak with
// the offset of its first occurrence, the count of samples strictly above
// threshold and the offset of the first sample at or above threshold; integral
// and times come out multiplied by sample_period (picoseconds) and wrapped to
// their field widths. A waveform with an empty gate or a peak below threshold
// reports zeros with time_of_arrival = -1. Rate: one sample transaction per
// clock while the summary queue is not full, set by the combinational
// accumulator update in the front stage. A waveform's summary passes through
// the summary queue, the multiply stage and the output register. The
// four-entry summary queue absorbs result stalls; samples stall only when it
// is full. Write configuration only while no waveform is in flight.
module gated_pulse_feature_extractor #(
	parameter int unsigned MAX_SAMPLES = gpfe_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned SAMPLE_BITS = gpfe_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gpfe_sample_if.sink                      samples,
	gpfe_result_if.source                    results,
	input  logic                             cfg_we,
	input  logic [gpfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gpfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gpfe_pkg::*;

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_empty;
	logic     q_push;
	logic     q_pop;
	summary_t q_in;
	summary_t q_out;

	// Configuration registers: take a write on every enabled edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= THRESHOLD_RST;
			cfg_q.gate_start    <= GATE_START_RST;
			cfg_q.gate_length   <= GATE_LENGTH_RST;
			cfg_q.sample_period <= SAMPLE_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD:     cfg_q.threshold     <= signed'(cfg_data[THR_W-1:0]);
				REG_GATE_START:    cfg_q.gate_start    <= cfg_data[GS_W-1:0];
				REG_GATE_LENGTH:   cfg_q.gate_length   <= cfg_data[GL_W-1:0];
				REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data[PER_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: accumulate gated features, hand one summary per waveform to the queue
	gpfe_front #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_in)
	);

	// Queue: decouple sample intake from result delivery
	gpfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.pop_data  (q_out)
	);

	// Back: scale by the sample period, apply suppression, hold the result
	gpfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_period (cfg_q.sample_period),
		.q_empty       (q_empty),
		.q_data        (q_out),
		.q_pop         (q_pop),
		.results       (results)
	);

endmodule

[rtl/gpfe_front.sv]
module gpfe_front #(
	parameter int unsigned MAX_SAMPLES = gpfe_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned SAMPLE_BITS = gpfe_pkg::SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	gpfe_sample_if.sink        samples,
	input  gpfe_pkg::cfg_t     cfg,
	input  logic               q_full,
	output logic               q_push,
	output gpfe_pkg::summary_t q_data
);
	import gpfe_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned DIF_W = ((IDX_W > GL_W) ? IDX_W : GL_W) + 1;
	localparam int unsigned CMP_W = 33;
	localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_SAMPLES);
	localparam logic signed [SAMPLE_BITS-1:0] MAX_RST = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [IDX_W-1:0]              idx_q;
	logic [SUM_W-1:0]              sum_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic [OFF_W-1:0]              max_off_q;
	logic [OFF_W-1:0]              over_q;
	logic [OFF_W-1:0]              arr_q;
	logic                          found_q;
	logic                          seen_q;

	logic                          accept;
	logic [DIF_W-1:0]              idx_ext;
	logic [DIF_W-1:0]              gs_ext;
	logic [DIF_W-1:0]              diff;
	logic                          gated;
	logic [OFF_W-1:0]              off;
	logic signed [CMP_W-1:0]       s_wide;
	logic signed [CMP_W-1:0]       thr_wide;
	logic signed [CMP_W-1:0]       max_wide;
	logic signed [31:0]            max32;
	logic                          take_max;
	logic                          take_arr;

	logic [IDX_W-1:0]              idx_n;
	logic [SUM_W-1:0]              sum_n;
	logic signed [SAMPLE_BITS-1:0] max_n;
	logic [OFF_W-1:0]              max_off_n;
	logic [OFF_W-1:0]              over_n;
	logic [OFF_W-1:0]              arr_n;
	logic                          found_n;
	logic                          seen_n;

	assign samples.ready = !q_full;
	assign accept        = samples.valid && samples.ready;

	// Gate test: index in [gate_start, gate_start + gate_length) and below the limit
	assign idx_ext = DIF_W'(idx_q);
	assign gs_ext  = DIF_W'(cfg.gate_start);
	assign diff    = idx_ext - gs_ext;
	assign gated   = (idx_q < IDX_LIMIT) && (idx_ext >= gs_ext) &&
	                 (diff < DIF_W'(cfg.gate_length));
	assign off     = diff[OFF_W-1:0];

	assign s_wide   = CMP_W'(samples.sample);
	assign thr_wide = CMP_W'(cfg.threshold);
	assign take_max = gated && (!seen_q || samples.sample > max_q);
	assign take_arr = gated && !found_q && (s_wide >= thr_wide);

	always_comb begin
		idx_n     = (idx_q < IDX_LIMIT) ? idx_q + IDX_W'(1) : idx_q;
		sum_n     = gated ? sum_q + SUM_W'(samples.sample) : sum_q;
		max_n     = take_max ? samples.sample : max_q;
		max_off_n = take_max ? off : max_off_q;
		over_n    = (gated && (s_wide > thr_wide)) ? over_q + OFF_W'(1) : over_q;
		arr_n     = take_arr ? off : arr_q;
		found_n   = found_q || take_arr;
		seen_n    = seen_q || gated;
	end

	assign max_wide = CMP_W'(max_n);
	assign max32    = 32'(max_n);

	// Summary includes the last sample itself
	assign q_push                = accept && samples.last_sample;
	assign q_data.hit            = seen_n && (max_wide >= thr_wide);
	assign q_data.sum            = sum_n;
	assign q_data.peak           = max32[PEAK_W-1:0];
	assign q_data.over_count     = over_n;
	assign q_data.arrival_offset = arr_n;
	assign q_data.peak_offset    = max_off_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			sum_q     <= '0;
			max_q     <= MAX_RST;
			max_off_q <= '0;
			over_q    <= '0;
			arr_q     <= '0;
			found_q   <= 1'b0;
			seen_q    <= 1'b0;
		end else if (accept) begin
			if (samples.last_sample) begin
				idx_q     <= '0;
				sum_q     <= '0;
				max_q     <= MAX_RST;
				max_off_q <= '0;
				over_q    <= '0;
				arr_q     <= '0;
				found_q   <= 1'b0;
				seen_q    <= 1'b0;
			end else begin
				idx_q     <= idx_n;
				sum_q     <= sum_n;
				max_q     <= max_n;
				max_off_q <= max_off_n;
				over_q    <= over_n;
				arr_q     <= arr_n;
				found_q   <= found_n;
				seen_q    <= seen_n;
			end
		end
	end

endmodule

[rtl/gpfe_queue.sv]
module gpfe_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gpfe_pkg::summary_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output gpfe_pkg::summary_t pop_data
);
	import gpfe_pkg::*;

	summary_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("summary queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("summary queue read while empty");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("summary queue count lost a push");

endmodule

[rtl/gpfe_back.sv]
module gpfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gpfe_pkg::PER_W-1:0]  sample_period,
	input  logic                        q_empty,
	input  gpfe_pkg::summary_t          q_data,
	output logic                        q_pop,
	gpfe_result_if.source               results
);
	import gpfe_pkg::*;

	logic                          valid_s1;
	logic                          hit_s1;
	logic [SUM_LO_W+PER_W-1:0]     lo_prod_s1;
	logic [SUM_HI_W-1:0]           hi_prod_s1;
	logic [PEAK_W-1:0]             peak_s1;
	logic [TOT_W-1:0]              tot_s1;
	logic [TOA_W-1:0]              toa_s1;
	logic [TOP_W-1:0]              top_s1;
	logic                          out_valid_q;
	logic                          adv2;
	logic [SUM_W-1:0]              integral_s1;

	// Output register is free when empty or being drained this cycle
	assign adv2  = valid_s1 && (!out_valid_q || results.ready);
	assign q_pop = !q_empty && (!valid_s1 || adv2);

	assign results.valid = out_valid_q;

	// Integral low 44 bits from the split product
	assign integral_s1 = lo_prod_s1[SUM_W-1:0] + {hi_prod_s1, {SUM_LO_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hit_s1     <= q_data.hit;
			lo_prod_s1 <= (SUM_LO_W+PER_W)'(q_data.sum[SUM_LO_W-1:0]) *
			              (SUM_LO_W+PER_W)'(sample_period);
			hi_prod_s1 <= q_data.sum[SUM_W-1:SUM_LO_W] * sample_period[SUM_HI_W-1:0];
			peak_s1    <= q_data.peak;
			tot_s1     <= TOT_W'(q_data.over_count) * TOT_W'(sample_period);
			toa_s1     <= TOA_W'(q_data.arrival_offset) * TOA_W'(sample_period);
			top_s1     <= TOP_W'(q_data.peak_offset) * TOP_W'(sample_period);
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			if (hit_s1) begin
				results.above_threshold     <= 1'b1;
				results.integral            <= signed'(integral_s1);
				results.peak_value          <= signed'(peak_s1);
				results.time_over_threshold <= tot_s1;
				results.time_of_arrival     <= signed'(toa_s1);
				results.time_of_peak        <= top_s1;
			end else begin
				results.above_threshold     <= 1'b0;
				results.integral            <= '0;
				results.peak_value          <= '0;
				results.time_over_threshold <= '0;
				results.time_of_arrival     <= signed'(ARRIVAL_NONE);
				results.time_of_peak        <= '0;
			end
		end
	end

endmodule
